// ===== design/lgic_pkg.sv =====
package lgic_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW = 21;
  localparam int unsigned MirrorDepth = 26;
  localparam int unsigned MirrorAw = 5;

  localparam logic [IdxW-1:0] GroupBase = 21'd257;
  localparam logic [IdxW-1:0] RootIdx = 21'd26;
  localparam logic [IdxW-1:0] ZeroEnd = 21'd256;
  localparam logic [WordW-1:0] RootMax = 32'h001f_ffe5;
  localparam logic [WordW-1:0] HeadMark = 32'h0000_0300;
  localparam logic [WordW-1:0] TailMark = 32'h0000_0200;
  localparam logic [7:0] LetterSpace = 8'h20;
  localparam logic [7:0] LetterA = 8'h61;
  localparam logic [7:0] LetterZ = 8'h7a;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SEC1,
    PH_SEC2,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] root_first;
    logic [IdxW-1:0] root_second;
  } verdict_t;

endpackage

// ===== design/letter_graph_image_checker_unit.sv =====
// the check stage after the input register forms each verdict for the output register
// throughput: one word per cycle from the single check stage, unless a last word stalls
// on a full output register; a verdict waits there while further words keep flowing in
// reset (rst_n, synchronous, active low) clears the handshake and checker state
// the 26-entry mirror buffer is not cleared; entries are written before they are read
module letter_graph_image_checker_unit
  import lgic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WordW-1:0] in_word,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_valid_res,
  output logic [IdxW-1:0]  out_root_first,
  output logic [IdxW-1:0]  out_root_second
);

  logic             s_valid;
  logic [WordW-1:0] s_word;
  logic             s_last;
  logic             s_take;
  logic             res_free;
  logic             res_load;
  verdict_t         res_data;

  lgic_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .in_last  (in_last),
    .s_valid  (s_valid),
    .s_word   (s_word),
    .s_last   (s_last),
    .s_take   (s_take)
  );

  lgic_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (s_valid),
    .s_word   (s_word),
    .s_last   (s_last),
    .s_take   (s_take),
    .res_free (res_free),
    .res_load (res_load),
    .res_data (res_data)
  );

  lgic_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_load        (res_load),
    .res_data        (res_data),
    .res_free        (res_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_valid_res   (out_valid_res),
    .out_root_first  (out_root_first),
    .out_root_second (out_root_second)
  );

endmodule

// ===== design/lgic_in_reg.sv =====
module lgic_in_reg
  import lgic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WordW-1:0] in_word,
  input  logic             in_last,
  output logic             s_valid,
  output logic [WordW-1:0] s_word,
  output logic             s_last,
  input  logic             s_take
);

  logic             valid_r;
  logic             valid_nxt;
  logic [WordW-1:0] word_r;
  logic             last_r;
  logic             load;

  assign in_ready = !valid_r || s_take;
  assign load = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (s_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
      last_r <= in_last;
    end
  end

  assign s_valid = valid_r;
  assign s_word = word_r;
  assign s_last = last_r;

endmodule

// ===== design/lgic_core.sv =====
module lgic_core
  import lgic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  input  logic [WordW-1:0] s_word,
  input  logic             s_last,
  output logic             s_take,
  input  logic             res_free,
  output logic             res_load,
  output verdict_t         res_data
);

  phase_t          phase_r, phase_nxt;
  logic [IdxW-1:0] pos_r, pos_nxt;
  logic [IdxW-1:0] root1_r, root1_nxt;
  logic [IdxW-1:0] root2_r, root2_nxt;
  logic [IdxW-1:0] gstart_r, gstart_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic            failed_r, failed_nxt;

  logic [WordW-1:0] mirror_r [MirrorDepth];
  logic             mir_we;
  logic [MirrorAw-1:0] mir_waddr;
  logic [MirrorAw-1:0] mir_raddr;
  logic [WordW-1:0] mir_rdata;

  logic [IdxW-1:0] root;
  logic [IdxW-1:0] kdiff;
  logic [IdxW:0]   pos_inc;
  logic [IdxW:0]   sec_end_idx;
  logic [7:0]      letter;
  logic            ends;
  logic [IdxW:0]   child;
  logic            chk_fail;
  logic            in_root;
  logic            fail_now;

  assign s_take = s_valid && (!s_last || res_free);
  assign res_load = s_take && s_last;

  assign root = (phase_r == PH_SEC1) ? root1_r : root2_r;
  assign kdiff = pos_r - root;
  assign in_root = (pos_r >= root) && (kdiff < RootIdx);
  assign mir_raddr = kdiff[MirrorAw-1:0];
  assign mir_rdata = mirror_r[mir_raddr];
  assign letter = s_word[7:0];
  assign ends = s_word[9];
  assign child = s_word[WordW-1:10];
  assign pos_inc = {1'b0, pos_r} + {{IdxW{1'b0}}, 1'b1};
  assign sec_end_idx = {1'b0, root} + {1'b0, RootIdx};
  assign mir_waddr = MirrorAw'(pos_r - 21'd1);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt = pos_r;
    root1_nxt = root1_r;
    root2_nxt = root2_r;
    gstart_nxt = gstart_r;
    prev_nxt = prev_r;
    failed_nxt = failed_r;
    chk_fail = 1'b0;
    mir_we = 1'b0;
    fail_now = failed_r;
    res_data.ok = 1'b0;
    res_data.root_first = '0;
    res_data.root_second = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r == 21'd1 || pos_r == 21'd2) begin
          if (s_word < {11'd0, GroupBase} || s_word > RootMax) begin
            failed_nxt = 1'b1;
          end
          if (pos_r == 21'd1) begin
            root1_nxt = s_word[IdxW-1:0];
          end else begin
            root2_nxt = s_word[IdxW-1:0];
          end
        end
        if (pos_r == 21'd2) begin
          phase_nxt = PH_SEC1;
          pos_nxt = '0;
          gstart_nxt = GroupBase;
          prev_nxt = '0;
        end else begin
          pos_nxt = pos_inc[IdxW-1:0];
        end
      end
      PH_SEC1, PH_SEC2: begin
        if (!failed_r) begin
          if (pos_r == '0) begin
            chk_fail = (s_word != HeadMark);
          end else if (pos_r <= RootIdx) begin
            mir_we = 1'b1;
          end else if (pos_r < ZeroEnd) begin
            chk_fail = (s_word != '0);
          end else if (pos_r == ZeroEnd) begin
            chk_fail = (s_word != TailMark);
          end else begin
            if (letter != LetterSpace && (letter < LetterA || letter > LetterZ)) begin
              chk_fail = 1'b1;
            end
            if (letter <= prev_r) begin
              chk_fail = 1'b1;
            end
            if (s_word[WordW-1]) begin
              chk_fail = 1'b1;
            end
            if (child != '0 && (child < {1'b0, GroupBase} || child >= {1'b0, gstart_r})) begin
              chk_fail = 1'b1;
            end
            if (in_root) begin
              if (mir_rdata != s_word) begin
                chk_fail = 1'b1;
              end
              if (letter != LetterA + 8'(kdiff)) begin
                chk_fail = 1'b1;
              end
              if (ends != (kdiff == 21'd25)) begin
                chk_fail = 1'b1;
              end
            end
            if (pos_r == root && gstart_r != root) begin
              chk_fail = 1'b1;
            end
            if (ends) begin
              gstart_nxt = pos_inc[IdxW-1:0];
              prev_nxt = '0;
            end else begin
              prev_nxt = letter;
            end
          end
        end
        fail_now = failed_r || chk_fail;
        failed_nxt = fail_now;
        pos_nxt = pos_inc[IdxW-1:0];
        if (pos_inc >= sec_end_idx) begin
          if (!fail_now && {1'b0, gstart_nxt} != sec_end_idx) begin
            failed_nxt = 1'b1;
          end
          phase_nxt = (phase_r == PH_SEC1) ? PH_SEC2 : PH_DONE;
          pos_nxt = '0;
          gstart_nxt = GroupBase;
          prev_nxt = '0;
        end
      end
      PH_DONE: begin
        failed_nxt = 1'b1;
      end
      default: begin
        failed_nxt = 1'b1;
      end
    endcase

    if (s_last) begin
      res_data.ok = !failed_nxt && (phase_nxt == PH_DONE);
      res_data.root_first = res_data.ok ? root1_nxt : '0;
      res_data.root_second = res_data.ok ? root2_nxt : '0;
      phase_nxt = PH_HEADER;
      pos_nxt = '0;
      root1_nxt = '0;
      root2_nxt = '0;
      gstart_nxt = GroupBase;
      prev_nxt = '0;
      failed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r <= '0;
      root1_r <= '0;
      root2_r <= '0;
      gstart_r <= GroupBase;
      prev_r <= '0;
      failed_r <= 1'b0;
    end else if (s_take) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      root1_r <= root1_nxt;
      root2_r <= root2_nxt;
      gstart_r <= gstart_nxt;
      prev_r <= prev_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take && mir_we) begin
      mirror_r[mir_waddr] <= s_word;
    end
  end

endmodule

// ===== design/lgic_out_reg.sv =====
module lgic_out_reg
  import lgic_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_load,
  input  verdict_t        res_data,
  output logic            res_free,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_valid_res,
  output logic [IdxW-1:0] out_root_first,
  output logic [IdxW-1:0] out_root_second
);

  logic     valid_r;
  logic     valid_nxt;
  verdict_t data_r;

  assign res_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_valid_res = data_r.ok;
  assign out_root_first = data_r.root_first;
  assign out_root_second = data_r.root_second;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

import lgic_pkg::*;

class image_verdict_board;
  verdict_t pending_verdicts[$];
  int unsigned mismatches;
  int unsigned verdicts_checked;
  int unsigned valid_seen;

  phase_t stage;
  logic [IdxW-1:0] entry_idx;
  logic [IdxW-1:0] root1;
  logic [IdxW-1:0] root2;
  logic [IdxW-1:0] open_group;
  logic [7:0] last_letter;
  logic [WordW-1:0] root_copy[MirrorDepth];
  bit broken;

  function new();
    mismatches = 0;
    verdicts_checked = 0;
    valid_seen = 0;
    restart();
  endfunction

  function void open_section();
    entry_idx = '0;
    open_group = GroupBase;
    last_letter = '0;
  endfunction

  function void restart();
    stage = PH_HEADER;
    root1 = '0;
    root2 = '0;
    broken = 0;
    open_section();
  endfunction

  function void check_entry(logic [WordW-1:0] w, logic [IdxW-1:0] i, logic [IdxW-1:0] r);
    logic [21:0] child;
    logic [7:0] letter;
    logic ends;
    logic [IdxW-1:0] k;
    child = w[31:10];
    letter = w[7:0];
    ends = w[9];
    if (i == 0) begin
      if (w != HeadMark) broken = 1;
      return;
    end
    if (i <= RootIdx) begin
      root_copy[i - 1'b1] = w;
      return;
    end
    if (i < ZeroEnd) begin
      if (w != '0) broken = 1;
      return;
    end
    if (i == ZeroEnd) begin
      if (w != TailMark) broken = 1;
      return;
    end
    if (letter != LetterSpace && (letter < LetterA || letter > LetterZ)) broken = 1;
    if (letter <= last_letter) broken = 1;
    if (w[31]) broken = 1;
    if (child != 0 && (child < GroupBase || child >= open_group)) broken = 1;
    if (i >= r && (i - r) < RootIdx) begin
      k = i - r;
      if (root_copy[k] != w) broken = 1;
      if (letter != LetterA + k[7:0]) broken = 1;
      if (ends != (k == RootIdx - 1'b1)) broken = 1;
    end
    if (i == r && open_group != r) broken = 1;
    if (ends) begin
      open_group = i + 1'b1;
      last_letter = '0;
    end else begin
      last_letter = letter;
    end
  endfunction

  function void note_word(logic [WordW-1:0] w, logic last);
    logic [IdxW-1:0] r;
    logic [31:0] sec_len;
    verdict_t v;
    case (stage)
      PH_HEADER: begin
        if (entry_idx == 1 || entry_idx == 2) begin
          if (w < GroupBase || w > RootMax) broken = 1;
          if (entry_idx == 1) root1 = w[IdxW-1:0];
          else root2 = w[IdxW-1:0];
        end
        if (entry_idx == 2) begin
          stage = PH_SEC1;
          open_section();
        end else begin
          entry_idx++;
        end
      end
      PH_SEC1, PH_SEC2: begin
        r = (stage == PH_SEC1) ? root1 : root2;
        sec_len = 32'(r) + 32'd26;
        if (!broken) check_entry(w, entry_idx, r);
        entry_idx++;
        if (32'(entry_idx) >= sec_len) begin
          if (!broken && 32'(open_group) != sec_len) broken = 1;
          stage = (stage == PH_SEC1) ? PH_SEC2 : PH_DONE;
          open_section();
        end
      end
      default: broken = 1;
    endcase
    if (last) begin
      v.ok = !broken && stage == PH_DONE;
      v.root_first = v.ok ? root1 : '0;
      v.root_second = v.ok ? root2 : '0;
      pending_verdicts.push_back(v);
      restart();
    end
  endfunction

  function void check_verdict(logic ok, logic [IdxW-1:0] rf, logic [IdxW-1:0] rs);
    verdict_t v;
    if (pending_verdicts.size() == 0) begin
      $error("verdict with none expected: valid_res %0d", ok);
      mismatches++;
      return;
    end
    v = pending_verdicts.pop_front();
    verdicts_checked++;
    if (v.ok) valid_seen++;
    if (ok !== v.ok) begin
      $error("valid_res: expected %0d, got %0d", v.ok, ok);
      mismatches++;
    end
    if (rf !== v.root_first) begin
      $error("root_first: expected %0d, got %0d", v.root_first, rf);
      mismatches++;
    end
    if (rs !== v.root_second) begin
      $error("root_second: expected %0d, got %0d", v.root_second, rs);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  typedef enum int {
    IMG_VALID,
    IMG_OVERLONG,
    IMG_TRUNCATED,
    IMG_FLIPPED,
    IMG_NOISE
  } image_kind_t;

  localparam int unsigned HoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WordW-1:0] in_word = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_valid_res;
  logic [IdxW-1:0] out_root_first;
  logic [IdxW-1:0] out_root_second;

  image_verdict_board board = new();

  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned images_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  letter_graph_image_checker_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_valid_res(out_valid_res),
    .out_root_first(out_root_first),
    .out_root_second(out_root_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_word(in_word, in_last);
      if (out_valid === 1'b1 && out_ready) begin
        board.check_verdict(out_valid_res, out_root_first, out_root_second);
      end
    end
  end

  // receiver: rotating stall pattern plus requested hold-offs
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_served++;
      end else begin
        case ((cyc / 128) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (cyc % 5 == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [WordW-1:0] w, input logic l);
    in_valid <= 1'b1;
    in_word <= w;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_image(ref logic [WordW-1:0] img[$]);
    foreach (img[i]) send_word(img[i], i == img.size() - 1);
    images_sent++;
  endtask

  function automatic int unsigned pick_root();
    if ($urandom_range(0, 9) == 0) return 257 + $urandom_range(0, 100);
    return 257 + $urandom_range(0, 12);
  endfunction

  function automatic void add_section(input int unsigned r, ref logic [WordW-1:0] img[$]);
    logic [WordW-1:0] sec[];
    logic [21:0] child;
    logic [7:0] letter;
    int unsigned at;
    int unsigned gstart;
    int unsigned need;
    sec = new[r + 26];
    foreach (sec[i]) sec[i] = '0;
    sec[0] = HeadMark;
    sec[256] = TailMark;
    at = 257;
    while (at < r) begin
      need = $urandom_range(1, (r - at < 27) ? r - at : 27);
      gstart = at;
      for (int j = 0; j < 27 && need > 0; j++) begin
        if ($urandom_range(0, 26 - j) < need) begin
          letter = (j == 0) ? LetterSpace : LetterA + 8'(j - 1);
          child = (gstart > 257 && $urandom_range(0, 1) == 1) ?
                  22'($urandom_range(257, gstart - 1)) : 22'd0;
          sec[at] = {child, need == 1, 1'($urandom_range(0, 1)), letter};
          at++;
          need--;
        end
      end
    end
    for (int k = 0; k < 26; k++) begin
      child = (r > 257 && $urandom_range(0, 3) != 0) ? 22'($urandom_range(257, r - 1)) : 22'd0;
      sec[r + k] = {child, k == 25, 1'($urandom_range(0, 1)), LetterA + 8'(k)};
    end
    for (int k = 0; k < 26; k++) sec[1 + k] = sec[r + k];
    foreach (sec[i]) img.push_back(sec[i]);
  endfunction

  function automatic void build_image(input image_kind_t kind, ref logic [WordW-1:0] img[$]);
    int unsigned p;
    int unsigned b;
    int unsigned cut;
    img.delete();
    if (kind == IMG_NOISE) begin
      img.push_back($urandom);
      repeat (2) img.push_back($urandom_range(0, 1) ? $urandom_range(257, 300) : $urandom);
      repeat ($urandom_range(0, 10)) img.push_back($urandom_range(0, 3) == 0 ? HeadMark : $urandom);
      return;
    end
    img.push_back($urandom);
    img.push_back(pick_root());
    img.push_back(pick_root());
    add_section(img[1], img);
    add_section(img[2], img);
    case (kind)
      IMG_OVERLONG: repeat ($urandom_range(1, 3)) img.push_back($urandom);
      IMG_TRUNCATED: begin
        cut = $urandom_range(1, img.size() - 1);
        while (img.size() > cut) void'(img.pop_back());
      end
      IMG_FLIPPED: begin
        repeat ($urandom_range(1, 2)) begin
          p = $urandom_range(0, 1) ? $urandom_range(260, img.size() - 1)
                                   : $urandom_range(0, img.size() - 1);
          b = $urandom_range(0, 31);
          img[p][b] = ~img[p][b];
        end
      end
      default: ;
    endcase
  endfunction

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [WordW-1:0] img[$];
    image_kind_t kind;
    int unsigned pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short images: header cut off, roots at and beyond the legal range
    img = '{32'hffff_ffff};
    send_image(img);
    img = '{32'h0, 32'(GroupBase)};
    send_image(img);
    img = '{32'h0, RootMax, 32'(GroupBase)};
    send_image(img);
    img = '{32'h0, 32'd256, 32'h101, HeadMark};
    send_image(img);
    img = '{32'h0, 32'h101, RootMax + 1, 32'h0};
    send_image(img);
    img = '{32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0};
    send_image(img);
    img = '{32'h0, 32'h0, 32'h0, 32'h0};
    send_image(img);

    // stall the output while short images keep arriving
    hold_requests++;
    burst_left = 200;
    repeat (30) begin
      img.delete();
      repeat ($urandom_range(1, 3)) img.push_back($urandom);
      send_image(img);
    end

    while (words_sent < 1800) begin
      if (images_sent < 42) begin
        kind = image_kind_t'(images_sent % 5);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) kind = IMG_VALID;
        else if (pick < 40) kind = IMG_OVERLONG;
        else if (pick < 50) kind = IMG_TRUNCATED;
        else if (pick < 75) kind = IMG_FLIPPED;
        else kind = IMG_NOISE;
      end
      build_image(kind, img);
      send_image(img);
    end
    in_valid <= 1'b0;

    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words in %0d images, one %0d-cycle output hold-off",
             words_sent, images_sent, HoldCycles);
    $display("checked %0d verdicts, %0d of them for well-formed images",
             board.verdicts_checked, board.valid_seen);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
